// File: rtl/avni_pkg.sv
// Shared types, widths and register codes for the affine nearest voxel index block.
`timescale 1ns / 1ps

package avni_pkg;

    localparam int COORD_W     = 10;
    localparam int COEF_W      = 16;
    localparam int OFF_W       = 24;
    localparam int ROW_W       = 3 * COEF_W;
    localparam int DIM_FIELD_W = 11;
    localparam int DIMS_W      = 3 * DIM_FIELD_W;
    localparam int IDX_W       = 30;
    localparam int PROD_W      = COEF_W + COORD_W + 1;
    localparam int SUM_W       = 30;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = ROW_W;

    localparam int MAX_DIM_DEF   = 1024;
    localparam int FRAC_BITS_DEF = 10;

    localparam logic [ROW_W-1:0]  ROW_I_RST = 48'd1024;
    localparam logic [ROW_W-1:0]  ROW_J_RST = 48'd67108864;
    localparam logic [ROW_W-1:0]  ROW_K_RST = 48'd4398046511104;
    localparam logic [DIMS_W-1:0] DIMS_RST  = 33'd67633408;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_I  = 3'd0,
        CFG_ROW_J  = 3'd1,
        CFG_ROW_K  = 3'd2,
        CFG_OFF_I  = 3'd3,
        CFG_OFF_J  = 3'd4,
        CFG_OFF_K  = 3'd5,
        CFG_DIMS   = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0] out_i;
        logic [COORD_W-1:0] out_j;
        logic [COORD_W-1:0] out_k;
        logic               last_voxel;
    } voxel_t;

    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic             in_range;
        logic             last_out;
    } result_t;

endpackage

// File: rtl/affine_nearest_voxel_index.sv
// Top level: affine voxel map, nearest rounding, range check and linear source index.
// Throughput: one voxel per cycle unless a held result stalls the pipeline.
// Each row multiply and each index multiply owns a stage.
// A held result (result_ready low) freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and loads the identity map, zero offsets, 256 x 256 x 16.
// Configuration is taken in any cycle (cfg_ready is always high).
`timescale 1ns / 1ps

module affine_nearest_voxel_index
    import avni_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  voxel_valid,
    output logic                  voxel_ready,
    input  voxel_t                voxel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int STAGES = 7;
    localparam int Q_W    = SUM_W - FRAC_BITS + 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CRD_W  = $clog2(MAX_DIM);
    localparam int KP_W   = DIM_W + CRD_W;
    localparam int T_W    = KP_W + 1;
    localparam int P_W    = DIM_W + T_W;
    localparam int CMP_W  = (Q_W > DIM_W) ? Q_W : DIM_W;
    localparam logic [DIM_FIELD_W:0] MAX_DIM_V = (DIM_FIELD_W + 1)'(MAX_DIM);

    logic [ROW_W-1:0]         row_reg [3];
    logic signed [OFF_W-1:0]  off_reg [3];
    logic [DIMS_W-1:0]        dims_reg;

    logic [DIM_FIELD_W:0]     dim_field [3];
    logic [DIM_W-1:0]         dim       [3];

    logic                     en;
    logic [STAGES-1:0]        valid_reg;
    logic                     last_reg [STAGES];
    logic signed [Q_W-1:0]    q [3];

    logic                     ok_next;
    logic                     ok4_reg, ok5_reg, ok6_reg, ok7_reg;
    logic [CRD_W-1:0]         i4_reg, j4_reg, i5_reg, i6_reg;
    logic [KP_W-1:0]          kprod_next, kprod_reg;
    logic [T_W-1:0]           t_next, t_reg;
    logic [P_W-1:0]           p_next, p_reg;
    logic [IDX_W-1:0]         idx_next, idx_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_I_RST;
            row_reg[1] <= ROW_J_RST;
            row_reg[2] <= ROW_K_RST;
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
            dims_reg   <= DIMS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROW_I: row_reg[0] <= cfg_data[ROW_W-1:0];
                CFG_ROW_J: row_reg[1] <= cfg_data[ROW_W-1:0];
                CFG_ROW_K: row_reg[2] <= cfg_data[ROW_W-1:0];
                CFG_OFF_I: off_reg[0] <= $signed(cfg_data[OFF_W-1:0]);
                CFG_OFF_J: off_reg[1] <= $signed(cfg_data[OFF_W-1:0]);
                CFG_OFF_K: off_reg[2] <= $signed(cfg_data[OFF_W-1:0]);
                CFG_DIMS:  dims_reg   <= cfg_data[DIMS_W-1:0];
                default:   ;
            endcase
        end
    end

    // saturate each dimension to MAX_DIM
    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            dim_field[n] = {1'b0, dims_reg[DIM_FIELD_W*n +: DIM_FIELD_W]};
            dim[n] = (dim_field[n] > MAX_DIM_V) ? DIM_W'(MAX_DIM_V) : DIM_W'(dim_field[n]);
        end
    end

    // whole pipeline advances together; hold everything while the result waits
    assign en           = !valid_reg[STAGES-1] || result_ready;
    assign voxel_ready  = en;
    assign result_valid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], voxel_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg[0] <= voxel.last_voxel;
            for (int s = 1; s < STAGES; s++)
            begin
                last_reg[s] <= last_reg[s-1];
            end
        end
    end

    // stages 1 to 3: the three affine rows
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        avni_row #(
            .FRAC_BITS (FRAC_BITS),
            .Q_W       (Q_W)
        ) u_row (
            .clk    (clk),
            .en     (en),
            .coeffs (row_reg[r]),
            .offset (off_reg[r]),
            .ci     (voxel.out_i),
            .cj     (voxel.out_j),
            .ck     (voxel.out_k),
            .q      (q[r])
        );
    end

    // stage 4: range check and d2 * k
    always_comb
    begin
        ok_next = 1'b1;
        for (int n = 0; n < 3; n++)
        begin
            ok_next = ok_next && !q[n][Q_W-1]
                    && (CMP_W'($unsigned(q[n])) < CMP_W'(dim[n]));
        end
        kprod_next = KP_W'(dim[1]) * KP_W'(q[2][CRD_W-1:0]);
    end

    // stages 5 to 7: j + d2*k, times d1, plus i
    assign t_next   = T_W'(j4_reg) + T_W'(kprod_reg);
    assign p_next   = P_W'(dim[0]) * P_W'(t_reg);
    assign idx_next = ok6_reg ? IDX_W'((P_W + 1)'(i6_reg) + (P_W + 1)'(p_reg)) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok4_reg   <= ok_next;
            i4_reg    <= q[0][CRD_W-1:0];
            j4_reg    <= q[1][CRD_W-1:0];
            kprod_reg <= kprod_next;
            ok5_reg   <= ok4_reg;
            i5_reg    <= i4_reg;
            t_reg     <= t_next;
            ok6_reg   <= ok5_reg;
            i6_reg    <= i5_reg;
            p_reg     <= p_next;
            ok7_reg   <= ok6_reg;
            idx_reg   <= idx_next;
        end
    end

    assign result.source_index = idx_reg;
    assign result.in_range     = ok7_reg;
    assign result.last_out     = last_reg[STAGES-1];

    a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
        (voxel_valid && voxel_ready) |=> valid_reg[0])
        else $error("accepted request did not enter the first stage");

    a_stall_freezes : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_reg))
        else $error("stage valid bits moved during a stall");

    a_fill_index_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.in_range) |-> (result.source_index == '0))
        else $error("out-of-range result carries a nonzero index");

    a_drain_to_output : assert property (@(posedge clk) disable iff (!rst_n)
        (en && valid_reg[STAGES-2]) |=> result_valid)
        else $error("last stage item did not reach the output");

endmodule

// File: rtl/avni_row.sv
// One affine row: three products, sum with offset, round half to even.
`timescale 1ns / 1ps

module avni_row
    import avni_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int Q_W       = SUM_W - FRAC_BITS + 1
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [ROW_W-1:0]         coeffs,
    input  logic signed [OFF_W-1:0]  offset,
    input  logic [COORD_W-1:0]       ci,
    input  logic [COORD_W-1:0]       cj,
    input  logic [COORD_W-1:0]       ck,
    output logic signed [Q_W-1:0]    q
);

    localparam int FLR_W = SUM_W - FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic signed [COEF_W-1:0]    coef      [3];
    logic signed [COORD_W:0]     crd       [3];
    logic signed [PROD_W-1:0]    prod_next [3];
    logic signed [PROD_W-1:0]    prod_reg  [3];
    logic signed [OFF_W-1:0]     off_reg;
    logic signed [SUM_W-1:0]     sum_next;
    logic signed [SUM_W-1:0]     sum_reg;
    logic signed [FLR_W-1:0]     flr;
    logic [FRAC_BITS-1:0]        rem;
    logic                        round_up;
    logic signed [Q_W-1:0]       q_next;
    logic signed [Q_W-1:0]       q_reg;

    always_comb
    begin
        crd[0] = $signed({1'b0, ci});
        crd[1] = $signed({1'b0, cj});
        crd[2] = $signed({1'b0, ck});
        for (int n = 0; n < 3; n++)
        begin
            coef[n]      = $signed(coeffs[COEF_W*n +: COEF_W]);
            prod_next[n] = PROD_W'(coef[n]) * PROD_W'(crd[n]);
        end
    end

    assign sum_next = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2])
                    + SUM_W'(off_reg);

    // floor is the arithmetic shift; bump on more than half, or half with odd floor
    always_comb
    begin
        flr      = sum_reg[SUM_W-1:FRAC_BITS];
        rem      = sum_reg[FRAC_BITS-1:0];
        round_up = (rem > HALF) || ((rem == HALF) && flr[0]);
        q_next   = Q_W'(flr) + Q_W'($signed({1'b0, round_up}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            off_reg  <= offset;
            sum_reg  <= sum_next;
            q_reg    <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// File: verif/affine_nearest_voxel_index_tb.sv
// Self-checking testbench for the affine nearest voxel index block.
`timescale 1ns / 1ps

module affine_nearest_voxel_index_tb;
    import avni_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int PIPE_DEPTH   = 7;
    localparam int LIMIT_CYCLES = 200000;
    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int UNIT         = 1 << FRAC;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 120;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // Expected source indexes, computed from a private copy of the map registers.
    class voxel_scoreboard;
        logic [ROW_W-1:0]  rows [3];
        logic [OFF_W-1:0]  offs [3];
        logic [DIMS_W-1:0] dims;
        result_t           pending [$];
        int                errors;

        function void load_defaults();
            rows[0] = ROW_I_RST;
            rows[1] = ROW_J_RST;
            rows[2] = ROW_K_RST;
            offs[0] = '0;
            offs[1] = '0;
            offs[2] = '0;
            dims    = DIMS_RST;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROW_I: rows[0] = data;
                CFG_ROW_J: rows[1] = data;
                CFG_ROW_K: rows[2] = data;
                CFG_OFF_I: offs[0] = data[OFF_W-1:0];
                CFG_OFF_J: offs[1] = data[OFF_W-1:0];
                CFG_OFF_K: offs[2] = data[OFF_W-1:0];
                CFG_DIMS:  dims    = data[DIMS_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact row sum, then round half to even at the fraction point.
        function longint map_axis(int axis, voxel_t v);
            longint acc;
            longint q;
            longint frac;
            longint half;
            acc = longint'($signed(rows[axis][COEF_W-1:0])) * longint'(v.out_i)
                + longint'($signed(rows[axis][2*COEF_W-1:COEF_W])) * longint'(v.out_j)
                + longint'($signed(rows[axis][3*COEF_W-1:2*COEF_W])) * longint'(v.out_k)
                + longint'($signed(offs[axis]));
            half = longint'(1) << (FRAC - 1);
            q    = acc >>> FRAC;
            frac = acc & ((longint'(1) << FRAC) - 1);
            if (frac > half || (frac == half && q[0]))
                q++;
            return q;
        endfunction

        function longint dim_size(int axis);
            longint d;
            d = longint'(dims[axis*DIM_FIELD_W +: DIM_FIELD_W]);
            return (d > MAX_DIM_DEF) ? longint'(MAX_DIM_DEF) : d;
        endfunction

        function void note_voxel(voxel_t v);
            longint  pos [3];
            longint  extent [3];
            longint  lin;
            bit      hit;
            int      a;
            result_t r;
            hit = 1'b1;
            for (a = 0; a < 3; a++) begin
                pos[a]    = map_axis(a, v);
                extent[a] = dim_size(a);
                if (pos[a] < 0 || pos[a] >= extent[a])
                    hit = 1'b0;
            end
            lin = hit ? pos[0] + extent[0] * (pos[1] + extent[1] * pos[2]) : 0;
            r.source_index = lin[IDX_W-1:0];
            r.in_range     = hit;
            r.last_out     = v.last_voxel;
            pending.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: source_index %0d in_range %0b last_out %0b",
                       got.source_index, got.in_range, got.last_out);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.source_index !== want.source_index) begin
                $error("source_index: expected %0d, got %0d", want.source_index,
                       got.source_index);
                errors++;
            end
            if (got.in_range !== want.in_range) begin
                $error("in_range: expected %0b, got %0b", want.in_range, got.in_range);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  voxel_valid;
    logic                  voxel_ready;
    voxel_t                voxel;
    logic                  result_valid;
    logic                  result_ready;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bit              steady = 1'b0;
    int              cycles = 0;
    voxel_scoreboard sb     = new();

    affine_nearest_voxel_index u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .voxel_valid  (voxel_valid),
        .voxel_ready  (voxel_ready),
        .voxel        (voxel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic voxel_t make_voxel(int i, int j, int k, bit last);
        voxel_t v;
        v.out_i      = COORD_W'(i);
        v.out_j      = COORD_W'(j);
        v.out_k      = COORD_W'(k);
        v.last_voxel = last;
        return v;
    endfunction

    // Offer one request; valid stays up until the block takes it.
    task automatic send_voxel(input voxel_t v);
        if (!steady)
        begin
            while ($urandom_range(99) < 32)
            begin
                voxel_valid <= 1'b0;
                @(posedge clk);
            end
        end
        voxel_valid <= 1'b1;
        voxel       <= v;
        @(posedge clk);
        while (!voxel_ready)
            @(posedge clk);
        sb.note_voxel(v);
    endtask

    task automatic settle();
        voxel_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // Write the whole map; junk in the upper data bits must be dropped.
    task automatic load_map(input logic [ROW_W-1:0] ri, input logic [ROW_W-1:0] rj,
                            input logic [ROW_W-1:0] rk, input logic [OFF_W-1:0] oi,
                            input logic [OFF_W-1:0] oj, input logic [OFF_W-1:0] ok,
                            input logic [DIMS_W-1:0] d);
        write_reg(CFG_ROW_I, ri);
        write_reg(CFG_ROW_J, rj);
        write_reg(CFG_ROW_K, rk);
        write_reg(CFG_OFF_I, {24'($urandom), oi});
        write_reg(CFG_OFF_J, {24'($urandom), oj});
        write_reg(CFG_OFF_K, {24'($urandom), ok});
        write_reg(CFG_DIMS, {15'($urandom), d});
        write_reg(CFG_SPARE, {$urandom, 16'($urandom)});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic directed_cases();
        // reset map: identity into 256 x 256 x 16
        send_voxel(make_voxel(0, 0, 0, 0));
        send_voxel(make_voxel(255, 255, 15, 1));
        send_voxel(make_voxel(256, 0, 0, 0));
        send_voxel(make_voxel(0, 0, 16, 0));
        send_voxel(make_voxel(1023, 1023, 1023, 1));
        settle();

        // half-way offsets exercise ties to even; oversized dims saturate
        load_map(ROW_I_RST, ROW_J_RST, ROW_K_RST, 24'(UNIT / 2), 24'(-UNIT / 2),
                 24'(3 * UNIT / 2), {11'd2047, 11'd2047, 11'd2047});
        send_voxel(make_voxel(0, 0, 0, 0));
        send_voxel(make_voxel(1, 1, 1, 0));
        send_voxel(make_voxel(1023, 1023, 1021, 0));
        send_voxel(make_voxel(1022, 1023, 1021, 1));
        settle();

        // most negative and most positive coefficients and offsets
        load_map({3{16'h8000}}, {3{16'h7FFF}}, '0, 24'h7FFFFF, 24'h800000, '0,
                 {11'd1024, 11'd1024, 11'd1});
        send_voxel(make_voxel(0, 0, 0, 0));
        send_voxel(make_voxel(1023, 1023, 1023, 1));
        settle();

        // mirrored first axis reaches the largest index
        load_map({32'd0, 16'hFC00}, ROW_J_RST, ROW_K_RST, 24'(1023 * UNIT), '0, '0,
                 {11'd1024, 11'd1024, 11'd1024});
        send_voxel(make_voxel(1023, 5, 7, 0));
        send_voxel(make_voxel(0, 1023, 1023, 1));
        settle();

        // zero first dimension: nothing is in range
        load_map(ROW_I_RST, ROW_J_RST, ROW_K_RST, '0, '0, '0, {11'd16, 11'd256, 11'd0});
        send_voxel(make_voxel(0, 0, 0, 0));
        send_voxel(make_voxel(5, 5, 5, 1));
        settle();
    endtask

    // Axis permutation with gain 0.5..2.0 and a mirror now and then, small cross terms.
    task automatic random_map(input int dim_hi);
        logic [ROW_W-1:0]  row [3];
        logic [OFF_W-1:0]  off [3];
        logic [DIMS_W-1:0] d;
        int                shift;
        int                gain;
        int                extent;
        int                a;
        int                s;
        shift = $urandom_range(2);
        for (a = 0; a < 3; a++)
        begin
            extent = $urandom_range(dim_hi, 1);
            d[a*DIM_FIELD_W +: DIM_FIELD_W] = DIM_FIELD_W'(extent);
            if (extent > MAX_DIM_DEF)
                extent = MAX_DIM_DEF;
            for (s = 0; s < 3; s++)
                row[a][s*COEF_W +: COEF_W] =
                    $urandom_range(1) ? 16'(int'($urandom_range(64)) - 32) : 16'd0;
            gain = $urandom_range(2 * UNIT, UNIT / 2);
            if ($urandom_range(1))
            begin
                row[a][((a + shift) % 3)*COEF_W +: COEF_W] = 16'(-gain);
                off[a] = 24'((extent - 1) * UNIT + int'($urandom_range(1200)) - 600);
            end
            else
            begin
                row[a][((a + shift) % 3)*COEF_W +: COEF_W] = 16'(gain);
                off[a] = 24'(int'($urandom_range(1200)) - 600);
            end
        end
        load_map(row[0], row[1], row[2], off[0], off[1], off[2], d);
    endtask

    task automatic extreme_map();
        load_map({$urandom, 16'($urandom)}, {$urandom, 16'($urandom)},
                 {$urandom, 16'($urandom)}, 24'($urandom), 24'($urandom), 24'($urandom),
                 33'({$urandom, $urandom}));
    endtask

    task automatic run_voxels(input int count, input int coord_hi);
        voxel_t v;
        int     n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
                v = 31'($urandom);
            else
                v = make_voxel($urandom_range(coord_hi), $urandom_range(coord_hi),
                               $urandom_range(coord_hi), $urandom_range(7) == 0);
            if (n == count - 1)
                v.last_voxel = 1'b1;
            send_voxel(v);
        end
        settle();
    endtask

    // Result side: check at each edge, then pick ready for the next cycle.
    initial
    begin : result_sink
        int hold_left;
        int taken;
        hold_left = 0;
        taken     = 0;
        result_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                sb.check_result(result);
                taken++;
                if (taken == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(99) < 32)
                result_ready <= 1'b0;
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int p;
        sb.load_defaults();
        rst_n       <= 1'b0;
        voxel_valid <= 1'b0;
        voxel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_cases();

        for (p = 0; p < 9; p++)
        begin
            steady = (p == 4);
            if (p == 2)
                extreme_map();
            else
                random_map((p == 5) ? 2047 : 64);
            run_voxels(135, (p == 2 || p == 5) ? 1023 : 63);
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
